FILE: rtl/camera_orientation_basis_top_defines.svh
// assertion macros used by the camera basis sequencer
`ifndef CAMERA_ORIENTATION_BASIS_TOP_DEFINES_SVH
`define CAMERA_ORIENTATION_BASIS_TOP_DEFINES_SVH

// same-cycle implication
`define COB_AST_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("camera basis check failed");

// next-cycle implication
`define COB_AST_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("camera basis check failed");

`endif

FILE: rtl/cob_pkg.sv
// types, constants and microcode for the camera basis block
package cob_pkg;

    localparam int VEC_FRAC_BITS = 14;
    localparam int IFRAC         = 30;
    localparam int VSHIFT        = IFRAC - VEC_FRAC_BITS;
    localparam int PC_W          = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE30       = 34'sd1073741824;
    // ceil(2^35 / 45), exact quotient for dividends below 2^29
    localparam logic signed [32:0] TURN_RECIP  = 33'sd763549742;

    localparam logic [2:0] CMD_RIGHT = 3'd0;
    localparam logic [2:0] CMD_UP    = 3'd1;
    localparam logic [2:0] CMD_FWD   = 3'd2;
    localparam logic [2:0] CMD_YAW   = 3'd3;
    localparam logic [2:0] CMD_PITCH = 3'd4;
    localparam logic [2:0] CMD_HOME  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_HOME_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_YAW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_PITCH = 3'd4;

    typedef logic [4:0] cob_op_t;

    localparam cob_op_t OP_END      = 5'd0;
    localparam cob_op_t OP_MUL_MV   = 5'd1;
    localparam cob_op_t OP_POS_ADD  = 5'd2;
    localparam cob_op_t OP_MUL_TURN = 5'd3;
    localparam cob_op_t OP_ANGLE    = 5'd4;
    localparam cob_op_t OP_COR_YAW  = 5'd5;
    localparam cob_op_t OP_COR_PIT  = 5'd6;
    localparam cob_op_t OP_MUL_CPSY = 5'd7;
    localparam cob_op_t OP_F0       = 5'd8;
    localparam cob_op_t OP_MUL_CPCY = 5'd9;
    localparam cob_op_t OP_F2       = 5'd10;
    localparam cob_op_t OP_FWD      = 5'd11;
    localparam cob_op_t OP_MUL_F1F  = 5'd12;
    localparam cob_op_t OP_U        = 5'd13;
    localparam cob_op_t OP_CHK      = 5'd14;
    localparam cob_op_t OP_MUL_SQ   = 5'd15;
    localparam cob_op_t OP_SUM      = 5'd16;
    localparam cob_op_t OP_SQRT     = 5'd17;
    localparam cob_op_t OP_TEST     = 5'd18;
    localparam cob_op_t OP_DIV      = 5'd19;
    localparam cob_op_t OP_NRM      = 5'd20;
    localparam cob_op_t OP_SAVE_UN  = 5'd21;
    localparam cob_op_t OP_MUL_CA   = 5'd22;
    localparam cob_op_t OP_TMP      = 5'd23;
    localparam cob_op_t OP_MUL_CB   = 5'd24;
    localparam cob_op_t OP_R        = 5'd25;
    localparam cob_op_t OP_COMMIT   = 5'd26;

    localparam logic [PC_W-1:0] PC_MOVE  = 7'd0;
    localparam logic [PC_W-1:0] PC_NOP   = 7'd6;
    localparam logic [PC_W-1:0] PC_ANGLE = 7'd7;
    localparam logic [PC_W-1:0] PC_END   = 7'd66;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] amount;
    } cob_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
    } cob_out_t;

    typedef struct packed {
        cob_op_t    op;
        logic [1:0] idx;
    } cob_uop_t;

    typedef struct packed {
        logic     load;
        logic     op_valid;
        cob_uop_t uop;
        logic     out_load;
    } cob_ctl_t;

    typedef struct packed {
        logic busy;
        logic degen;
        logic out_free;
    } cob_stat_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:  return 32'h20000000;
            5'd1:  return 32'h12E4051E;
            5'd2:  return 32'h09FB385B;
            5'd3:  return 32'h051111D4;
            5'd4:  return 32'h028B0D43;
            5'd5:  return 32'h0145D7E1;
            5'd6:  return 32'h00A2F61E;
            5'd7:  return 32'h00517C55;
            5'd8:  return 32'h0028BE53;
            5'd9:  return 32'h00145F2F;
            5'd10: return 32'h000A2F98;
            5'd11: return 32'h000517CC;
            5'd12: return 32'h00028BE6;
            5'd13: return 32'h000145F3;
            5'd14: return 32'h0000A2F9;
            5'd15: return 32'h0000517C;
            5'd16: return 32'h000028BE;
            5'd17: return 32'h0000145F;
            5'd18: return 32'h00000A2F;
            5'd19: return 32'h00000517;
            5'd20: return 32'h0000028B;
            5'd21: return 32'h00000145;
            5'd22: return 32'h000000A2;
            5'd23: return 32'h00000051;
            5'd24: return 32'h00000028;
            5'd25: return 32'h00000014;
            5'd26: return 32'h0000000A;
            5'd27: return 32'h00000005;
            5'd28: return 32'h00000002;
            5'd29: return 32'h00000001;
            default: return 32'h0;
        endcase
    endfunction

    // round half up then arithmetic shift
    function automatic logic signed [65:0] rnd66(input logic signed [65:0] x, input int s);
        return (x + (66'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -66'sd2147483648)
            return 32'sh80000000;
        return 32'(x);
    endfunction

    function automatic logic uop_starts(input cob_op_t op);
        return op == OP_COR_YAW || op == OP_COR_PIT ||
               op == OP_SQRT || op == OP_DIV;
    endfunction

    // normalize sequence: check, squares and sums, sqrt, test, divides and results
    function automatic cob_uop_t norm_uop(input logic [PC_W-1:0] off);
        cob_uop_t u;
        logic [PC_W-1:0] t;
        u = '{op: OP_END, idx: 2'd0};
        if (off == 7'd0)
            u.op = OP_CHK;
        else if (off <= 7'd6)
        begin
            t     = off - 7'd1;
            u.op  = off[0] ? OP_MUL_SQ : OP_SUM;
            u.idx = t[2:1];
        end
        else if (off == 7'd7)
            u.op = OP_SQRT;
        else if (off == 7'd8)
            u.op = OP_TEST;
        else if (off <= 7'd14)
        begin
            t     = off - 7'd9;
            u.op  = off[0] ? OP_DIV : OP_NRM;
            u.idx = t[2:1];
        end
        return u;
    endfunction

    function automatic cob_uop_t ucode(input logic [PC_W-1:0] pc);
        cob_uop_t u;
        logic [PC_W-1:0] t;
        u = '{op: OP_END, idx: 2'd0};
        t = '0;
        if (pc <= 7'd5)
        begin
            u.op  = pc[0] ? OP_POS_ADD : OP_MUL_MV;
            u.idx = pc[2:1];
        end
        else if (pc == 7'd7)  u.op = OP_MUL_TURN;
        else if (pc == 7'd8)  u.op = OP_ANGLE;
        else if (pc == 7'd9)  u.op = OP_COR_YAW;
        else if (pc == 7'd10) u.op = OP_COR_PIT;
        else if (pc == 7'd11) u.op = OP_MUL_CPSY;
        else if (pc == 7'd12) u.op = OP_F0;
        else if (pc == 7'd13) u.op = OP_MUL_CPCY;
        else if (pc == 7'd14) u.op = OP_F2;
        else if (pc == 7'd15) u.op = OP_FWD;
        else if (pc >= 7'd16 && pc <= 7'd21)
        begin
            t     = pc - 7'd16;
            u.op  = pc[0] ? OP_U : OP_MUL_F1F;
            u.idx = t[2:1];
        end
        else if (pc >= 7'd22 && pc <= 7'd36)
            u = norm_uop(pc - 7'd22);
        else if (pc == 7'd37)
            u.op = OP_SAVE_UN;
        else if (pc >= 7'd38 && pc <= 7'd49)
        begin
            t     = pc - 7'd38;
            u.idx = t[3:2];
            case (t[1:0])
                2'd0:    u.op = OP_MUL_CA;
                2'd1:    u.op = OP_TMP;
                2'd2:    u.op = OP_MUL_CB;
                default: u.op = OP_R;
            endcase
        end
        else if (pc >= 7'd50 && pc <= 7'd64)
            u = norm_uop(pc - 7'd50);
        else if (pc == 7'd65)
            u.op = OP_COMMIT;
        return u;
    endfunction

endpackage

FILE: rtl/camera_orientation_basis_top.sv
// top level of the camera pose and basis block
// Camera pose engine: one result beat per command beat. Moves make three
// passes through the shared 33x33 multiplier. Yaw, pitch and go-home run a
// reciprocal multiply for the angle step, two CORDIC runs, two normalizations
// each made of a square root and three divides on the shared divider, plus
// multiply steps; a degenerate up vector cuts this short. The next command is
// taken while the previous result waits in the output register. Configuration
// writes take effect at once and no clearing pass runs.
module camera_orientation_basis_top #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cob_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [cob_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cob_pkg::cob_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cob_pkg::cob_out_t              out_data
);
    import cob_pkg::*;

    cob_ctl_t  ctl;
    cob_stat_t st;

    cob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_data.cmd),
        .ctl      (ctl),
        .st       (st)
    );

    cob_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .ctl       (ctl),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/cob_ctrl.sv
// microcoded sequencer for the camera basis datapath
`include "camera_orientation_basis_top_defines.svh"

module cob_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        in_cmd,
    output cob_pkg::cob_ctl_t ctl,
    input  cob_pkg::cob_stat_t st
);
    import cob_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    cob_uop_t        uop;

    function automatic logic [PC_W-1:0] entry(input logic [2:0] c);
        case (c) inside
            CMD_RIGHT, CMD_UP, CMD_FWD:  return PC_MOVE;
            CMD_YAW, CMD_PITCH, CMD_HOME: return PC_ANGLE;
            default:                      return PC_NOP;
        endcase
    endfunction

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        pc_next    = pc_reg;
        uop        = ucode(pc_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    pc_next    = entry(in_cmd);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (uop.op == OP_END)
                begin
                    if (st.out_free)
                    begin
                        ctl.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (uop.op == OP_TEST)
                    pc_next = st.degen ? PC_END : pc_reg + 7'd1;
                else
                begin
                    ctl.op_valid = 1'b1;
                    ctl.uop      = uop;
                    pc_next      = pc_reg + 7'd1;
                    if (uop_starts(uop.op))
                        state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!st.busy)
                    state_next = S_RUN;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= PC_MOVE;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    `COB_AST_NEXT(a_beat_starts_run, clk, rst_n, in_valid && in_ready, state_reg == S_RUN)
    `COB_AST_SAME(a_load_when_free, clk, rst_n, ctl.out_load, st.out_free)
    `COB_AST_SAME(a_no_op_in_wait, clk, rst_n, state_reg == S_WAIT, !ctl.op_valid)

endmodule

FILE: rtl/cob_dp.sv
// pose state, cordic, sqrt, divider and shared multiplier
module cob_dp #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cob_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [cob_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  cob_pkg::cob_in_t                      in_data,
    input  cob_pkg::cob_ctl_t                     ctl,
    output cob_pkg::cob_stat_t                    st,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cob_pkg::cob_out_t                     out_data
);
    import cob_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam logic [CNT_W-1:0] COR_LAST = CNT_W'(CORDIC_STEPS - 1);

    logic signed [31:0] home_x_reg, home_y_reg, home_z_reg;
    logic [15:0]        home_yaw_reg, home_pitch_reg;
    logic signed [31:0] pos_reg [3];
    logic [15:0]        yaw_reg, pitch_reg;
    logic signed [15:0] fwd_reg [3];
    logic signed [15:0] up_reg [3];
    logic signed [15:0] rgt_reg [3];
    logic               cor_busy_reg, sq_busy_reg, dv_busy_reg, out_valid_reg;

    logic [2:0]         icmd_reg;
    logic signed [31:0] amt_reg;
    logic signed [31:0] cy_reg, sy_reg, cp_reg, sp_reg;
    logic signed [31:0] f_reg [3];
    logic signed [33:0] v_reg [3];
    logic signed [32:0] c_reg [3];
    logic signed [31:0] n_reg [3];
    logic signed [31:0] un_reg [3];
    logic signed [65:0] prod_reg, tmp_reg;
    logic [63:0]        sum_reg;
    logic               any_reg;
    logic signed [33:0] cor_x_reg, cor_y_reg, cor_z_reg;
    logic               cor_flip_reg, cor_pit_reg;
    logic [CNT_W-1:0]   cor_cnt_reg;
    logic [63:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [4:0]         sq_cnt_reg;
    logic [63:0]        dv_num_reg;
    logic [32:0]        dv_rem_reg, dv_den_reg;
    logic [5:0]         dv_cnt_reg;
    cob_out_t           out_reg;

    logic               op_v;
    cob_op_t            op;
    logic [1:0]         k;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [15:0] mv_vec;
    logic signed [33:0] turn_n, turn_mag;
    logic [15:0]        turn_q;
    logic [15:0]        cor_ang;
    logic signed [33:0] cor_z0, cor_zi;
    logic               cor_fi;
    logic signed [33:0] cor_dx, cor_dy, cor_at, cor_xn, cor_yn, cor_zn;
    logic signed [33:0] cor_xf, cor_yf;
    logic [63:0]        sq_t;
    logic [33:0]        dv_sh;
    logic               dv_ge;
    logic               chk_any;
    logic signed [32:0] chk_c [3];
    logic signed [32:0] c_abs;
    logic [63:0]        div_num0;
    logic [31:0]        nrm_q;
    logic signed [65:0] u_r;

    assign op_v = ctl.op_valid;
    assign op   = ctl.uop.op;
    assign k    = ctl.uop.idx;

    // operand select for the shared multiplier
    always_comb
    begin
        case (icmd_reg)
            CMD_RIGHT: mv_vec = rgt_reg[k];
            CMD_UP:    mv_vec = up_reg[k];
            default:   mv_vec = fwd_reg[k];
        endcase
        c_abs = c_reg[k][32] ? -c_reg[k] : c_reg[k];
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_MV:
            begin
                mul_a = 33'(mv_vec);
                mul_b = 33'(amt_reg);
            end
            OP_MUL_TURN:
            begin
                mul_a = 33'(turn_mag >>> 3);
                mul_b = TURN_RECIP;
            end
            OP_MUL_CPSY:
            begin
                mul_a = 33'(cp_reg);
                mul_b = 33'(sy_reg);
            end
            OP_MUL_CPCY:
            begin
                mul_a = 33'(cp_reg);
                mul_b = 33'(cy_reg);
            end
            OP_MUL_F1F:
            begin
                mul_a = 33'(f_reg[1]);
                mul_b = 33'(f_reg[k]);
            end
            OP_MUL_SQ:
            begin
                mul_a = c_abs;
                mul_b = c_abs;
            end
            OP_MUL_CA:
            begin
                case (k)
                    2'd0:
                    begin
                        mul_a = 33'(f_reg[1]);
                        mul_b = 33'(un_reg[2]);
                    end
                    2'd1:
                    begin
                        mul_a = 33'(f_reg[2]);
                        mul_b = 33'(un_reg[0]);
                    end
                    default:
                    begin
                        mul_a = 33'(f_reg[0]);
                        mul_b = 33'(un_reg[1]);
                    end
                endcase
            end
            OP_MUL_CB:
            begin
                case (k)
                    2'd0:
                    begin
                        mul_a = 33'(f_reg[2]);
                        mul_b = 33'(un_reg[1]);
                    end
                    2'd1:
                    begin
                        mul_a = 33'(f_reg[0]);
                        mul_b = 33'(un_reg[2]);
                    end
                    default:
                    begin
                        mul_a = 33'(f_reg[1]);
                        mul_b = 33'(un_reg[0]);
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // angle step: floor(mag / 360) as floor(floor(mag / 8) / 45) by reciprocal
    assign turn_n   = 34'(amt_reg) + 34'sd180;
    assign turn_mag = turn_n[33] ? (34'sd359 - turn_n) : turn_n;
    assign turn_q   = turn_n[33] ? -prod_reg[50:35] : prod_reg[50:35];

    // cordic start and step
    always_comb
    begin
        cor_ang = (op == OP_COR_PIT) ? pitch_reg : yaw_reg;
        cor_z0  = 34'(signed'({cor_ang, 16'h0000}));
        cor_zi  = cor_z0;
        cor_fi  = 1'b0;
        if (cor_z0 > 34'sd1073741824)
        begin
            cor_zi = cor_z0 - 34'sd2147483648;
            cor_fi = 1'b1;
        end
        else if (cor_z0 < -34'sd1073741824)
        begin
            cor_zi = cor_z0 + 34'sd2147483648;
            cor_fi = 1'b1;
        end
        cor_dx = cor_y_reg >>> cor_cnt_reg;
        cor_dy = cor_x_reg >>> cor_cnt_reg;
        cor_at = $signed({2'b00, atan_entry(5'(cor_cnt_reg))});
        if (!cor_z_reg[33])
        begin
            cor_xn = cor_x_reg - cor_dx;
            cor_yn = cor_y_reg + cor_dy;
            cor_zn = cor_z_reg - cor_at;
        end
        else
        begin
            cor_xn = cor_x_reg + cor_dx;
            cor_yn = cor_y_reg - cor_dy;
            cor_zn = cor_z_reg + cor_at;
        end
        cor_xf = cor_flip_reg ? -cor_xn : cor_xn;
        cor_yf = cor_flip_reg ? -cor_yn : cor_yn;
    end

    // sqrt and divider steps
    assign sq_t  = sq_res_reg + sq_bit_reg;
    assign dv_sh = {dv_rem_reg, dv_num_reg[63]};
    assign dv_ge = dv_sh >= {1'b0, dv_den_reg};

    // normalize helpers
    always_comb
    begin
        chk_any = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (rnd66(66'(v_reg[i]), VSHIFT) != 66'sd0)
                chk_any = 1'b1;
            if (v_reg[i] > 34'sd2147483648)
                chk_c[i] = 33'sd2147483648;
            else if (v_reg[i] < -34'sd2147483648)
                chk_c[i] = -33'sd2147483648;
            else
                chk_c[i] = 33'(v_reg[i]);
        end
        div_num0 = {c_abs[31:0], 30'b0} + 64'(sq_res_reg[32:1]);
        nrm_q    = (dv_num_reg > 64'd1073741824) ? 32'd1073741824 : dv_num_reg[31:0];
        u_r      = rnd66(prod_reg, IFRAC);
    end

    assign st.busy     = cor_busy_reg | sq_busy_reg | dv_busy_reg;
    assign st.degen    = !any_reg || (sq_res_reg[32:0] == 33'd0);
    assign st.out_free = !out_valid_reg || out_ready;

    // architectural state and unit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_x_reg     <= '0;
            home_y_reg     <= '0;
            home_z_reg     <= '0;
            home_yaw_reg   <= '0;
            home_pitch_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                fwd_reg[i] <= '0;
                up_reg[i]  <= '0;
                rgt_reg[i] <= '0;
            end
            fwd_reg[2]    <= 16'sd16384;
            up_reg[1]     <= 16'sd16384;
            rgt_reg[0]    <= -16'sd16384;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            cor_busy_reg  <= 1'b0;
            sq_busy_reg   <= 1'b0;
            dv_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_HOME_X:     home_x_reg     <= cfg_data;
                    CFG_HOME_Y:     home_y_reg     <= cfg_data;
                    CFG_HOME_Z:     home_z_reg     <= cfg_data;
                    CFG_HOME_YAW:   home_yaw_reg   <= cfg_data[15:0];
                    CFG_HOME_PITCH: home_pitch_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cor_busy_reg && cor_cnt_reg == COR_LAST)
                cor_busy_reg <= 1'b0;
            if (sq_busy_reg && sq_cnt_reg == 5'd31)
                sq_busy_reg <= 1'b0;
            if (dv_busy_reg && dv_cnt_reg == 6'd63)
                dv_busy_reg <= 1'b0;
            if (op_v)
            begin
                case (op) inside
                    OP_POS_ADD:
                        pos_reg[k] <= sat32(66'(pos_reg[k]) + rnd66(prod_reg, VEC_FRAC_BITS));
                    OP_ANGLE:
                    begin
                        if (icmd_reg == CMD_HOME)
                        begin
                            pos_reg[0] <= home_x_reg;
                            pos_reg[1] <= home_y_reg;
                            pos_reg[2] <= home_z_reg;
                            yaw_reg    <= home_yaw_reg;
                            pitch_reg  <= home_pitch_reg;
                        end
                        else if (icmd_reg == CMD_YAW)
                            yaw_reg <= yaw_reg - turn_q;
                        else
                            pitch_reg <= pitch_reg - turn_q;
                    end
                    OP_FWD:
                        for (int i = 0; i < 3; i++)
                            fwd_reg[i] <= 16'(rnd66(66'(f_reg[i]), VSHIFT));
                    OP_COMMIT:
                        for (int i = 0; i < 3; i++)
                        begin
                            up_reg[i]  <= 16'(rnd66(66'(un_reg[i]), VSHIFT));
                            rgt_reg[i] <= 16'(rnd66(66'(n_reg[i]), VSHIFT));
                        end
                    OP_DIV:
                        dv_busy_reg <= 1'b1;
                    OP_SQRT:
                        sq_busy_reg <= 1'b1;
                    OP_COR_YAW, OP_COR_PIT:
                        cor_busy_reg <= 1'b1;
                    default: ;
                endcase
            end
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            icmd_reg <= in_data.cmd;
            amt_reg  <= in_data.amount;
        end
        if (op_v)
        begin
            case (op) inside
                OP_MUL_MV, OP_MUL_TURN, OP_MUL_CPSY, OP_MUL_CPCY, OP_MUL_F1F,
                OP_MUL_SQ, OP_MUL_CA, OP_MUL_CB:
                    prod_reg <= mul_p;
                OP_COR_YAW, OP_COR_PIT:
                begin
                    cor_x_reg    <= CORDIC_GAIN;
                    cor_y_reg    <= '0;
                    cor_z_reg    <= cor_zi;
                    cor_flip_reg <= cor_fi;
                    cor_cnt_reg  <= '0;
                    cor_pit_reg  <= (op == OP_COR_PIT);
                end
                OP_F0:
                    f_reg[0] <= 32'(rnd66(prod_reg, IFRAC));
                OP_F2:
                begin
                    f_reg[2] <= 32'(rnd66(prod_reg, IFRAC));
                    f_reg[1] <= -sp_reg;
                end
                OP_U:
                    v_reg[k] <= (k == 2'd1) ? ONE30 - 34'(u_r) : -34'(u_r);
                OP_CHK:
                begin
                    any_reg <= chk_any;
                    sum_reg <= '0;
                    for (int i = 0; i < 3; i++)
                        c_reg[i] <= chk_c[i];
                end
                OP_SUM:
                    sum_reg <= sum_reg + prod_reg[63:0];
                OP_SQRT:
                begin
                    sq_n_reg   <= sum_reg;
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'h4000000000000000;
                    sq_cnt_reg <= '0;
                end
                OP_DIV:
                begin
                    dv_num_reg <= div_num0;
                    dv_rem_reg <= '0;
                    dv_den_reg <= sq_res_reg[32:0];
                    dv_cnt_reg <= '0;
                end
                OP_NRM:
                    n_reg[k] <= c_reg[k][32] ? -nrm_q : nrm_q;
                OP_SAVE_UN:
                    for (int i = 0; i < 3; i++)
                        un_reg[i] <= n_reg[i];
                OP_TMP:
                    tmp_reg <= prod_reg;
                OP_R:
                    v_reg[k] <= 34'(rnd66(tmp_reg - prod_reg, IFRAC));
                default: ;
            endcase
        end
        if (cor_busy_reg)
        begin
            cor_x_reg   <= cor_xn;
            cor_y_reg   <= cor_yn;
            cor_z_reg   <= cor_zn;
            cor_cnt_reg <= cor_cnt_reg + 1'b1;
            if (cor_cnt_reg == COR_LAST)
            begin
                if (cor_pit_reg)
                begin
                    cp_reg <= 32'(cor_xf);
                    sp_reg <= 32'(cor_yf);
                end
                else
                begin
                    cy_reg <= 32'(cor_xf);
                    sy_reg <= 32'(cor_yf);
                end
            end
        end
        if (sq_busy_reg)
        begin
            if (sq_n_reg >= sq_t)
            begin
                sq_n_reg   <= sq_n_reg - sq_t;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
                sq_res_reg <= sq_res_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
        if (dv_busy_reg)
        begin
            dv_rem_reg <= dv_ge ? 33'(dv_sh - {1'b0, dv_den_reg}) : dv_sh[32:0];
            dv_num_reg <= {dv_num_reg[62:0], dv_ge};
            dv_cnt_reg <= dv_cnt_reg + 1'b1;
        end
        if (ctl.out_load)
        begin
            out_reg.pos_x   <= pos_reg[0];
            out_reg.pos_y   <= pos_reg[1];
            out_reg.pos_z   <= pos_reg[2];
            out_reg.fwd_x   <= fwd_reg[0];
            out_reg.fwd_y   <= fwd_reg[1];
            out_reg.fwd_z   <= fwd_reg[2];
            out_reg.up_x    <= up_reg[0];
            out_reg.up_y    <= up_reg[1];
            out_reg.up_z    <= up_reg[2];
            out_reg.right_x <= rgt_reg[0];
            out_reg.right_y <= rgt_reg[1];
            out_reg.right_z <= rgt_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: verif/camera_orientation_basis_checker.sv
// camera pose checker: watches the channels, predicts each result beat and compares it
`timescale 1ns / 1ps

module camera_orientation_basis_checker #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic [cob_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [cob_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic     in_valid,
    input  logic     in_ready,
    input  cob_pkg::cob_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  cob_pkg::cob_out_t out_data,
    output int       fail_count,
    output int       pending,
    output int       results_seen
);
    import cob_pkg::*;

    localparam int VF = VEC_FRAC_BITS;
    localparam int IF_BITS = 30;
    localparam longint UNIT30 = 64'sd1 <<< IF_BITS;

    typedef longint vec3_t [3];

    localparam logic [31:0] ARCTAN [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    logic signed [31:0] home_x, home_y, home_z;
    logic [15:0]        home_yaw, home_pitch;
    logic signed [31:0] cam_pos [3];
    logic [15:0]        yaw, pitch;
    int                 fwd [3];
    int                 upv [3];
    int                 rgt [3];

    cob_out_t pose_q [$];

    assign pending = pose_q.size();

    function automatic longint round_shift(input longint x, input int s);
        if (s == 0)
            return x;
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic cordic_sincos(input logic [15:0] a, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z    = longint'($signed({a, 16'h0000}));
        x    = 652032874;
        y    = 0;
        flip = 0;
        if (z > (64'sd1 <<< 30))
        begin
            z    = z - (64'sd1 <<< 31);
            flip = 1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z    = z + (64'sd1 <<< 31);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ARCTAN[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ARCTAN[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic make_unit(input vec3_t v, output vec3_t o, output bit ok);
        longint          c [3];
        longint unsigned sum, len, m, q;
        bit              any;
        sum = 0;
        any = 0;
        ok  = 0;
        o   = '{0, 0, 0};
        for (int k = 0; k < 3; k++)
        begin
            if (round_shift(v[k], IF_BITS - VF) != 0)
                any = 1;
            c[k] = v[k];
            if (c[k] > (64'sd1 <<< 31))
                c[k] = 64'sd1 <<< 31;
            if (c[k] < -(64'sd1 <<< 31))
                c[k] = -(64'sd1 <<< 31);
            m   = (c[k] < 0) ? -c[k] : c[k];
            sum = sum + m * m;
        end
        if (!any)
            return;
        len = floor_sqrt(sum);
        if (len == 0)
            return;
        for (int k = 0; k < 3; k++)
        begin
            m = (c[k] < 0) ? -c[k] : c[k];
            q = ((m << IF_BITS) + len / 2) / len;
            if (q > UNIT30)
                q = UNIT30;
            o[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
        end
        ok = 1;
    endtask

    task automatic rebuild_basis();
        longint cy, sy, cp, sp;
        vec3_t  f, u, un, r, rn;
        bit     ok;
        cordic_sincos(yaw, cy, sy);
        cordic_sincos(pitch, cp, sp);
        f[0] = round_shift(cp * sy, IF_BITS);
        f[1] = -sp;
        f[2] = round_shift(cp * cy, IF_BITS);
        for (int k = 0; k < 3; k++)
            fwd[k] = int'(round_shift(f[k], IF_BITS - VF));
        u[0] = -round_shift(f[1] * f[0], IF_BITS);
        u[1] = UNIT30 - round_shift(f[1] * f[1], IF_BITS);
        u[2] = -round_shift(f[1] * f[2], IF_BITS);
        make_unit(u, un, ok);
        if (!ok)
            return;
        r[0] = round_shift(f[1] * un[2] - f[2] * un[1], IF_BITS);
        r[1] = round_shift(f[2] * un[0] - f[0] * un[2], IF_BITS);
        r[2] = round_shift(f[0] * un[1] - f[1] * un[0], IF_BITS);
        make_unit(r, rn, ok);
        if (!ok)
            return;
        for (int k = 0; k < 3; k++)
        begin
            upv[k] = int'(round_shift(un[k], IF_BITS - VF));
            rgt[k] = int'(round_shift(rn[k], IF_BITS - VF));
        end
    endtask

    task automatic step_along(input int v [3], input longint amt);
        longint d, p;
        for (int k = 0; k < 3; k++)
        begin
            d = round_shift(longint'(v[k]) * amt, VF);
            p = longint'(cam_pos[k]) + d;
            if (p > 64'sd2147483647)
                p = 64'sd2147483647;
            if (p < -64'sd2147483648)
                p = -64'sd2147483648;
            cam_pos[k] = p[31:0];
        end
    endtask

    function automatic logic [15:0] turn_angle(input logic [15:0] ang, input longint amt);
        longint n, q;
        n = amt + 180;
        if (n >= 0)
            q = n / 360;
        else
            q = -((-n + 359) / 360);
        return ang - q[15:0];
    endfunction

    task automatic predict_pose(input cob_in_t beat, output cob_out_t res);
        longint amt;
        amt = longint'(beat.amount);
        case (beat.cmd)
            CMD_RIGHT: step_along(rgt, amt);
            CMD_UP:    step_along(upv, amt);
            CMD_FWD:   step_along(fwd, amt);
            CMD_YAW:
            begin
                yaw = turn_angle(yaw, amt);
                rebuild_basis();
            end
            CMD_PITCH:
            begin
                pitch = turn_angle(pitch, amt);
                rebuild_basis();
            end
            CMD_HOME:
            begin
                cam_pos[0] = home_x;
                cam_pos[1] = home_y;
                cam_pos[2] = home_z;
                yaw        = home_yaw;
                pitch      = home_pitch;
                rebuild_basis();
            end
            default: ;
        endcase
        res.pos_x   = cam_pos[0];
        res.pos_y   = cam_pos[1];
        res.pos_z   = cam_pos[2];
        res.fwd_x   = fwd[0][15:0];
        res.fwd_y   = fwd[1][15:0];
        res.fwd_z   = fwd[2][15:0];
        res.up_x    = upv[0][15:0];
        res.up_y    = upv[1][15:0];
        res.up_z    = upv[2][15:0];
        res.right_x = rgt[0][15:0];
        res.right_y = rgt[1][15:0];
        res.right_z = rgt[2][15:0];
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got, inout bit bad);
        if (want !== got)
        begin
            if (fail_count < 10)
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, fname, want, got);
            fail_count++;
            bad = 1;
        end
    endtask

    task automatic compare_pose(input cob_out_t want, input cob_out_t got);
        bit bad;
        bad = 0;
        compare_field("pos_x", want.pos_x, got.pos_x, bad);
        compare_field("pos_y", want.pos_y, got.pos_y, bad);
        compare_field("pos_z", want.pos_z, got.pos_z, bad);
        compare_field("fwd_x", 32'(want.fwd_x), 32'(got.fwd_x), bad);
        compare_field("fwd_y", 32'(want.fwd_y), 32'(got.fwd_y), bad);
        compare_field("fwd_z", 32'(want.fwd_z), 32'(got.fwd_z), bad);
        compare_field("up_x", 32'(want.up_x), 32'(got.up_x), bad);
        compare_field("up_y", 32'(want.up_y), 32'(got.up_y), bad);
        compare_field("up_z", 32'(want.up_z), 32'(got.up_z), bad);
        compare_field("right_x", 32'(want.right_x), 32'(got.right_x), bad);
        compare_field("right_y", 32'(want.right_y), 32'(got.right_y), bad);
        compare_field("right_z", 32'(want.right_z), 32'(got.right_z), bad);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cob_out_t want;
        if (!rst_n)
        begin
            home_x       = 0;
            home_y       = 0;
            home_z       = 0;
            home_yaw     = 0;
            home_pitch   = 0;
            cam_pos      = '{0, 0, 0};
            yaw          = 0;
            pitch        = 0;
            fwd          = '{0, 0, 1 << VF};
            upv          = '{0, 1 << VF, 0};
            rgt          = '{-(1 << VF), 0, 0};
            fail_count   = 0;
            results_seen = 0;
            pose_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_HOME_X:     home_x     = cfg_data;
                    CFG_HOME_Y:     home_y     = cfg_data;
                    CFG_HOME_Z:     home_z     = cfg_data;
                    CFG_HOME_YAW:   home_yaw   = cfg_data[15:0];
                    CFG_HOME_PITCH: home_pitch = cfg_data[15:0];
                    default: ;
                endcase
            end
            // result beat first: it belongs to an earlier command
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pose_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t result beat with no command waiting", $realtime);
                    fail_count++;
                end
                else
                    compare_pose(pose_q.pop_front(), out_data);
            end
            if (in_valid && in_ready)
            begin
                predict_pose(in_data, want);
                pose_q.push_back(want);
            end
        end
    end

endmodule

FILE: verif/camera_orientation_basis_top_tb.sv
// testbench top for the camera pose block: stimulus, config phases and verdict
`timescale 1ns / 1ps

module camera_orientation_basis_top_tb;
    import cob_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int         PHASE_ITEMS  = 400;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic     in_valid;
    logic     in_ready;
    cob_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    cob_out_t out_data;
    int       fail_count;
    int       pending;
    int       results_seen;
    bit       calm;
    int       cmds_sent;
    int       cfg_writes;

    camera_orientation_basis_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    camera_orientation_basis_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("timeout with %0d results outstanding", pending);
        $display("** camera_orientation_basis_top: FAILED **");
        $finish;
    end

    // result side stall per beat
    initial
    begin
        int n;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n = calm ? 0 : $urandom_range(0, 8);
            if (n > 0)
            begin
                out_ready <= 0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1;
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_cmd(input logic [2:0] c, input logic signed [31:0] amt);
        int n;
        n = calm ? 0 : $urandom_range(0, 8);
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid       <= 1;
        in_data.cmd    <= c;
        in_data.amount <= amt;
        do
            @(posedge clk);
        while (!in_ready);
        cmds_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic load_home(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic [15:0] yw, input logic [15:0] pt);
        logic [31:0] vals [5];
        logic [CFG_IDX_W-1:0] idxs [5];
        vals = '{x, y, z, {16'h0, yw}, {16'h0, pt}};
        idxs = '{CFG_HOME_X, CFG_HOME_Y, CFG_HOME_Z, CFG_HOME_YAW, CFG_HOME_PITCH};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we   <= 1;
            cfg_idx  <= idxs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            cfg_writes++;
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_cmd();
        int r;
        logic [2:0] c;
        logic signed [31:0] amt;
        r = $urandom_range(0, 99);
        if (r < 18)      c = CMD_RIGHT;
        else if (r < 34) c = CMD_UP;
        else if (r < 50) c = CMD_FWD;
        else if (r < 66) c = CMD_YAW;
        else if (r < 82) c = CMD_PITCH;
        else if (r < 94) c = CMD_HOME;
        else             c = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        r = $urandom_range(0, 9);
        if (r < 3)
            amt = $urandom;
        else if (r < 6)
            amt = $signed($urandom_range(0, 2000000)) - 1000000;
        else if (r < 8)
            amt = ($signed($urandom_range(0, 65535)) - 32768) * 360
                  + $signed($urandom_range(0, 360)) - 180;
        else if (r < 9)
            amt = ($urandom_range(0, 1) ? 16384 : -16384) * 360;
        else
            amt = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        send_cmd(c, amt);
    endtask

    initial
    begin
        rst_n      = 0;
        cfg_we     = 0;
        cfg_idx    = '0;
        cfg_data   = '0;
        in_valid   = 0;
        in_data    = '0;
        calm       = 0;
        cmds_sent  = 0;
        cfg_writes = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every command, amount extremes, angle rounding edges
        send_cmd(CMD_RIGHT, 32'sh7FFFFFFF);
        send_cmd(CMD_RIGHT, 32'sh7FFFFFFF);
        send_cmd(CMD_UP, 32'sh80000000);
        send_cmd(CMD_UP, 32'sh80000000);
        send_cmd(CMD_FWD, 0);
        send_cmd(CMD_FWD, -1);
        send_cmd(CMD_YAW, 179);
        send_cmd(CMD_YAW, 180);
        send_cmd(CMD_YAW, -180);
        send_cmd(CMD_YAW, -181);
        send_cmd(CMD_PITCH, -16384 * 360);
        send_cmd(CMD_RIGHT, 65536);
        send_cmd(CMD_UP, 65536);
        send_cmd(CMD_PITCH, 32768 * 360);
        send_cmd(CMD_YAW, 32'sh7FFFFFFF);
        send_cmd(CMD_PITCH, 32'sh80000000);
        send_cmd(CMD_SPARE_LO, 32'sh7FFFFFFF);
        send_cmd(CMD_SPARE_HI, 32'sh80000000);
        send_cmd(CMD_HOME, 0);
        wait_idle();

        // home looking straight down, where the up vector degenerates
        load_home(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 16'hFFFF, 16'h4000);
        send_cmd(CMD_HOME, 0);
        send_cmd(CMD_FWD, 32'sh7FFFFFFF);
        send_cmd(CMD_YAW, 90 * 182);
        send_cmd(CMD_RIGHT, -65536);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: load_home($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
                1: load_home(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
                2: load_home(32'h80000000, 32'h80000000, 32'h80000000, 16'h0000, 16'h0000);
                default: load_home($urandom, $urandom, $urandom, 16'($urandom), 16'hC000);
            endcase
            calm = (ph == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_cmd();
            calm = 0;
            wait_idle();
        end

        $display("%0d commands sent, %0d results checked, %0d home register writes",
                 cmds_sent, results_seen, cfg_writes);
        $display("covered moves with saturation, turns, go-home and the straight-up pose");
        if (fail_count == 0 && pending == 0)
            $display("** camera_orientation_basis_top: PASSED **");
        else
            $display("** camera_orientation_basis_top: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/cob_pkg.sv
rtl/cob_ctrl.sv
rtl/cob_dp.sv
rtl/camera_orientation_basis_top.sv
verif/camera_orientation_basis_checker.sv
verif/camera_orientation_basis_top_tb.sv
